FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent must be followed by consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg
// shared types, constants and the character decoder of the bracket checker
// ----------------------------------------------------------------------------
package bnc_pkg;

	localparam int STACK_DEPTH_DEF = 1024;

	localparam int CHAR_W    = 8;
	localparam int STATUS_W  = 3;
	localparam int DEPTH_W   = 11;
	localparam int SCORE_W   = 48;
	localparam int WEIGHT_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int KIND_W    = 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// reset weights
	localparam logic [WEIGHT_W-1:0] WEIGHT_ROUND_RST  = 16'd3;
	localparam logic [WEIGHT_W-1:0] WEIGHT_SQUARE_RST = 16'd57;
	localparam logic [WEIGHT_W-1:0] WEIGHT_CURLY_RST  = 16'd1197;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ANGLE_RST  = 16'd25137;

	// bracket characters
	localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28; // (
	localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B; // [
	localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B; // {
	localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE   = 8'h3C; // <
	localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29; // )
	localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D; // ]
	localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D; // }
	localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E; // >

	typedef enum logic [KIND_W-1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_ANGLE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT_ROUND  = 2'd0,
		REG_WEIGHT_SQUARE = 2'd1,
		REG_WEIGHT_CURLY  = 2'd2,
		REG_WEIGHT_ANGLE  = 2'd3
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSH     = 3'd0,
		ST_POP      = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_SKIP     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic  is_open;
		logic  is_close;
		kind_t kind;
	} char_class_t;

	function automatic char_class_t decode_char(input logic [CHAR_W-1:0] ch);
		char_class_t c;
		c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
		unique case (ch)
			CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
			CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
			CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
			CH_OPEN_ANGLE:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
			CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
			CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
			CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
			CH_CLOSE_ANGLE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
			default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/bnc_weight_regs.sv
// ----------------------------------------------------------------------------
// bnc_weight_regs
// mismatch weight registers with write port and per-kind select
// ----------------------------------------------------------------------------
module bnc_weight_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bnc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bnc_pkg::WEIGHT_W-1:0]     cfg_data,
	input  bnc_pkg::kind_t                   kind,
	output logic [bnc_pkg::WEIGHT_W-1:0]     weight
);
	import bnc_pkg::*;

	logic [WEIGHT_W-1:0] weight_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q[KIND_ROUND]  <= WEIGHT_ROUND_RST;
			weight_q[KIND_SQUARE] <= WEIGHT_SQUARE_RST;
			weight_q[KIND_CURLY]  <= WEIGHT_CURLY_RST;
			weight_q[KIND_ANGLE]  <= WEIGHT_ANGLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WEIGHT_ROUND:  weight_q[KIND_ROUND]  <= cfg_data;
				REG_WEIGHT_SQUARE: weight_q[KIND_SQUARE] <= cfg_data;
				REG_WEIGHT_CURLY:  weight_q[KIND_CURLY]  <= cfg_data;
				REG_WEIGHT_ANGLE:  weight_q[KIND_ANGLE]  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign weight = weight_q[kind];

endmodule

FILE: rtl/core/bnc_stack_mem.sv
// ----------------------------------------------------------------------------
// bnc_stack_mem
// bracket stack storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bnc_stack_mem #(
	parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF,
	localparam int IDX_W = $clog2(STACK_DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [IDX_W-1:0] waddr,
	input  bnc_pkg::kind_t wdata,
	input  logic [IDX_W-1:0] raddr,
	output bnc_pkg::kind_t rdata
);
	import bnc_pkg::*;

	kind_t mem [STACK_DEPTH];
	kind_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-through so a push is visible as top in the next cycle
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/bracket_nesting_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_nesting_checker_unit
// streaming bracket nesting checker with a memory-backed stack
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------
// s_*      | in        | s_tvalid/s_tready  | tdata char_code, tlast end_of_line
// m_*      | out       | m_tvalid/m_tready  | tdata status, nesting_depth, score
// cfg_*    | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
// one item per cycle unless m_tready stalls, result in the cycle after the item is taken
// the stack top comes from a registered memory read addressed by the next
// pointer each cycle, with write-through for a push to the same entry
// reset clears pointer, failure mark, score and weights; stack contents
// need no clearing since only pushed entries are ever read
// the output register is refilled while its item is taken, so a stall on
// m_tready holds s_tready low only while the output is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_nesting_checker_unit #(
	parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] char_code
	input  logic                           s_tlast,   // end_of_line
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,   // [2:0] status, [13:3] nesting_depth,
	                                                  // [61:14] total_score, [63:62] zero
	// configuration
	input  logic                           cfg_we,
	input  logic [bnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bnc_pkg::WEIGHT_W-1:0]   cfg_data
);
	import bnc_pkg::*;

	localparam int PTR_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);

	// architectural state
	logic [PTR_W-1:0]   sp_q;
	logic               failed_q;
	logic [SCORE_W-1:0] score_q;

	// output register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [DEPTH_W-1:0] out_depth_q;
	logic [SCORE_W-1:0] out_score_q;

	logic               accept;
	char_class_t        cls;
	kind_t              top_kind;
	logic [WEIGHT_W-1:0] weight;

	// per-item decisions
	status_t            status_d;
	logic [PTR_W-1:0]   sp_op;       // pointer after the operation
	logic [PTR_W-1:0]   sp_d;        // pointer after the end-of-line clear
	logic               failed_d;
	logic [SCORE_W-1:0] score_d;
	logic [SCORE_W:0]   score_sum;
	logic               add_weight;

	// stack memory access
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [IDX_W-1:0]   mem_raddr;
	logic [PTR_W-1:0]   rd_ptr;
	logic [PTR_W+DEPTH_W-1:0] depth_ext;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cls      = decode_char(s_tdata);

	bnc_weight_regs u_weights (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kind      (cls.kind),
		.weight    (weight)
	);

	// main decision: push, pop, mismatch, skip or overflow
	always_comb begin
		status_d   = ST_SKIP;
		sp_op      = sp_q;
		failed_d   = failed_q;
		add_weight = 1'b0;
		mem_we     = 1'b0;
		if (accept) begin
			if (failed_q) begin
				status_d = ST_SKIP;
			end else if (cls.is_open) begin
				if (sp_q == PTR_FULL) begin
					// stack full, opener dropped and line fails
					status_d = ST_OVERFLOW;
					failed_d = 1'b1;
				end else begin
					status_d = ST_PUSH;
					mem_we   = 1'b1;
					sp_op    = sp_q + PTR_W'(1);
				end
			end else if (cls.is_close && (sp_q != '0) && (top_kind == cls.kind)) begin
				status_d = ST_POP;
				sp_op    = sp_q - PTR_W'(1);
			end else begin
				// wrong closer, close on empty stack, or any other character
				status_d   = ST_MISMATCH;
				failed_d   = 1'b1;
				add_weight = cls.is_close;
			end
		end
		sp_d = sp_op;
		if (accept && s_tlast) begin
			sp_d     = '0;
			failed_d = 1'b0;
		end
	end

	// saturating score update
	assign score_sum = {1'b0, score_q} + (SCORE_W+1)'(add_weight ? weight : '0);
	assign score_d   = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];

	// the memory is read at the new top every cycle
	assign mem_waddr = sp_q[IDX_W-1:0];
	assign rd_ptr    = sp_d - PTR_W'(1);
	assign mem_raddr = rd_ptr[IDX_W-1:0];

	bnc_stack_mem #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (cls.kind),
		.raddr (mem_raddr),
		.rdata (top_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			failed_q <= 1'b0;
			score_q  <= '0;
		end else if (accept) begin
			sp_q     <= sp_d;
			failed_q <= failed_d;
			score_q  <= score_d;
		end
	end

	// depth is the pointer before the end-of-line clear, kept to 11 bits
	assign depth_ext = (PTR_W+DEPTH_W)'(sp_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_d;
			out_depth_q  <= depth_ext[DEPTH_W-1:0];
			out_score_q  <= score_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_score_q, out_depth_q, out_status_q};

	// checks
	`ASSERT_PROP(a_sp_bound, clk, arst_n, sp_q <= PTR_FULL, "stack pointer beyond depth")
	`ASSERT_NEXT(a_push_top, clk, arst_n, accept && mem_we && !s_tlast,
		top_kind == $past(cls.kind), "pushed kind not on top next cycle")
	`ASSERT_PROP(a_skip_no_push, clk, arst_n, !(failed_q && mem_we),
		"push on a failed line")
	`ASSERT_NEXT(a_score_mono, clk, arst_n, 1'b1, score_q >= $past(score_q),
		"score decreased")

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming bracket nesting checker
//
// characters go in on the s_* stream and one result per character comes back
// on m_* ; an in-bench tracker keeps its own stack, failure mark, weights and
// score, predicts every result at the moment the item is taken, and the
// result monitor compares status, depth and score field by field in order
// both streams idle at random, the receiver also holds off for a long stretch
// so the block fills up and stalls its input
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bnc_pkg::*;

	localparam int DEPTH       = STACK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	// one predicted result item
	typedef struct {
		status_t             status;
		logic [DEPTH_W-1:0]  depth;
		logic [SCORE_W-1:0]  score;
	} bracket_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] char_code
	logic                  s_tlast;   // end_of_line
	logic                  m_tvalid;
	logic                  m_tready;
	logic [63:0]           m_tdata;   // [2:0] status, [13:3] nesting_depth,
	                                  // [61:14] total_score, [63:62] zero
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [WEIGHT_W-1:0]   cfg_data;

	// tracker state, mirrors what the block should hold
	kind_t                 line_stack [DEPTH];
	int                    line_depth;
	bit                    line_failed;
	logic [SCORE_W-1:0]    score_total;
	logic [WEIGHT_W-1:0]   kind_weight [4];

	bracket_result_t       expected_results [$];

	int                    errors;
	int                    items_sent;
	int                    cycle_count;
	// idle probability in percent for each side, and a one-shot long hold
	int                    src_gap_pct;
	int                    sink_gap_pct;
	int                    sink_hold;

	bracket_nesting_checker_unit #(
		.STACK_DEPTH (DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mostly no gap, sometimes a short one, now and then a long one
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] bracket_char(input kind_t k, input bit closing);
		case (k)
			KIND_ROUND:  return closing ? CH_CLOSE_ROUND  : CH_OPEN_ROUND;
			KIND_SQUARE: return closing ? CH_CLOSE_SQUARE : CH_OPEN_SQUARE;
			KIND_CURLY:  return closing ? CH_CLOSE_CURLY  : CH_OPEN_CURLY;
			default:     return closing ? CH_CLOSE_ANGLE  : CH_OPEN_ANGLE;
		endcase
	endfunction

	// advance the tracker by one character and return the result it implies
	function automatic bracket_result_t track_char(input logic [7:0] ch, input logic eol);
		bracket_result_t r;
		bit              is_open;
		bit              is_close;
		kind_t           k;
		logic [SCORE_W:0] sum;
		is_open  = 1'b0;
		is_close = 1'b0;
		k        = KIND_ROUND;
		case (ch)
			CH_OPEN_ROUND:   begin is_open  = 1'b1; k = KIND_ROUND;  end
			CH_OPEN_SQUARE:  begin is_open  = 1'b1; k = KIND_SQUARE; end
			CH_OPEN_CURLY:   begin is_open  = 1'b1; k = KIND_CURLY;  end
			CH_OPEN_ANGLE:   begin is_open  = 1'b1; k = KIND_ANGLE;  end
			CH_CLOSE_ROUND:  begin is_close = 1'b1; k = KIND_ROUND;  end
			CH_CLOSE_SQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
			CH_CLOSE_CURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
			CH_CLOSE_ANGLE:  begin is_close = 1'b1; k = KIND_ANGLE;  end
			default: ;
		endcase

		if (line_failed) begin
			// rest of a failed line is ignored
			r.status = ST_SKIP;
		end else if (is_open) begin
			if (line_depth >= DEPTH) begin
				r.status    = ST_OVERFLOW;
				line_failed = 1'b1;
			end else begin
				line_stack[line_depth] = k;
				line_depth++;
				r.status = ST_PUSH;
			end
		end else if (is_close && line_depth > 0 && line_stack[line_depth-1] == k) begin
			line_depth--;
			r.status = ST_POP;
		end else begin
			// wrong closer, closer on empty stack, or any other byte (weight zero)
			sum = {1'b0, score_total} + (SCORE_W+1)'(is_close ? kind_weight[k] : '0);
			score_total = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
			line_failed = 1'b1;
			r.status    = ST_MISMATCH;
		end
		r.depth = DEPTH_W'(line_depth);
		r.score = score_total;

		// depth is reported before the end-of-line clear
		if (eol) begin
			line_depth  = 0;
			line_failed = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// offer one character, wait for it to be taken, then predict its result
	task automatic send_char(input logic [7:0] ch, input logic eol);
		int gap;
		gap = pick_gap(src_gap_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= eol;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(track_char(ch, eol));
		items_sent++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		// one result per item, so an empty queue means every result is back
		repeat (4) @(posedge clk);
	endtask

	// write all four weights while the block is idle
	task automatic load_weights(input logic [15:0] w_round, input logic [15:0] w_square,
			input logic [15:0] w_curly, input logic [15:0] w_angle);
		logic [15:0] w [4];
		w[0] = w_round;
		w[1] = w_square;
		w[2] = w_curly;
		w[3] = w_angle;
		drain_results();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= w[i];
			@(posedge clk);
			kind_weight[i] = w[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one random line: mostly nested brackets, some broken, some plain noise
	task automatic send_random_line();
		logic [7:0] line [$];
		kind_t      open_kinds [$];
		int         shape;
		int         n_open;
		int         n_tail;
		kind_t      k;
		shape  = $urandom_range(99);
		n_open = ($urandom_range(19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
		if (shape < 85) begin
			while (n_open > 0 || open_kinds.size() > 0) begin
				if (n_open > 0 && (open_kinds.size() == 0 || $urandom_range(1) == 1)) begin
					k = kind_t'($urandom_range(3));
					open_kinds.push_back(k);
					line.push_back(bracket_char(k, 1'b0));
					n_open--;
				end else begin
					line.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
				end
				// some lines end with brackets still open, broken ones stop anywhere
				if (shape >= 45 && $urandom_range(9) == 0)
					break;
			end
			if (shape >= 60) begin
				if ($urandom_range(2) != 0) begin
					// closer of the wrong kind, or any closer on an empty stack
					k = kind_t'($urandom_range(3));
					if (open_kinds.size() > 0 && k == open_kinds[$])
						k = kind_t'((int'(k) + 1) % 4);
					line.push_back(bracket_char(k, 1'b1));
				end else begin
					line.push_back(8'($urandom_range(255)));
				end
				// trailing characters that should be skipped
				n_tail = $urandom_range(3);
				repeat (n_tail)
					line.push_back(($urandom_range(1) == 1) ? 8'($urandom_range(255)) :
						bracket_char(kind_t'($urandom_range(3)), 1'($urandom_range(1))));
			end
		end else begin
			n_tail = $urandom_range(1, 8);
			repeat (n_tail)
				line.push_back(($urandom_range(1) == 1) ? 8'($urandom_range(255)) :
					bracket_char(kind_t'($urandom_range(3)), 1'($urandom_range(1))));
		end
		foreach (line[i])
			send_char(line[i], i == line.size() - 1);
	endtask

	// receiver side: random stalls plus an occasional long hold
	initial begin : sink_proc
		int stall;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else begin
				stall = pick_gap(sink_gap_pct);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// result monitor, compares against the oldest prediction
	always @(posedge clk) begin : result_check
		bracket_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata, '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[2:0] !== want.status)
					report_mismatch("status", 64'(m_tdata[2:0]), 64'(want.status));
				if (m_tdata[13:3] !== want.depth)
					report_mismatch("nesting_depth", 64'(m_tdata[13:3]), 64'(want.depth));
				if (m_tdata[61:14] !== want.score)
					report_mismatch("total_score", 64'(m_tdata[61:14]), 64'(want.score));
				if (m_tdata[63:62] !== 2'b00)
					report_mismatch("tdata padding", 64'(m_tdata[63:62]), '0);
			end
		end
	end

	// every opener, matched pops, closers on an empty stack, wrong closer
	// followed by skipped characters, byte extremes as non-brackets
	task automatic test_directed();
		src_gap_pct  = 20;
		sink_gap_pct = 20;
		send_char(CH_OPEN_ROUND, 1'b0);
		send_char(CH_CLOSE_ROUND, 1'b1);
		send_char(CH_OPEN_ROUND, 1'b0);
		send_char(CH_OPEN_SQUARE, 1'b0);
		send_char(CH_OPEN_CURLY, 1'b0);
		send_char(CH_OPEN_ANGLE, 1'b0);
		send_char(CH_CLOSE_ANGLE, 1'b0);
		send_char(CH_CLOSE_CURLY, 1'b0);
		send_char(CH_CLOSE_SQUARE, 1'b0);
		send_char(CH_CLOSE_ROUND, 1'b1);
		// closers with nothing open, one per line
		send_char(CH_CLOSE_ROUND, 1'b1);
		send_char(CH_CLOSE_SQUARE, 1'b1);
		send_char(CH_CLOSE_CURLY, 1'b1);
		send_char(CH_CLOSE_ANGLE, 1'b1);
		// wrong closer, then the rest of the line is skipped
		send_char(CH_OPEN_ROUND, 1'b0);
		send_char(CH_CLOSE_SQUARE, 1'b0);
		send_char(8'h78, 1'b1);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		drain_results();
	endtask

	// weights at both extremes and at random values, each seen on a mismatch
	task automatic test_weights();
		load_weights('0, '0, '0, '0);
		for (int k = 0; k < 4; k++)
			send_char(bracket_char(kind_t'(k), 1'b1), 1'b1);
		load_weights('1, '1, '1, '1);
		for (int k = 0; k < 4; k++)
			send_char(bracket_char(kind_t'(k), 1'b1), 1'b1);
		load_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		for (int k = 0; k < 4; k++) begin
			send_char(bracket_char(kind_t'(k), 1'b0), 1'b0);
			send_char(bracket_char(kind_t'((k + 1) % 4), 1'b1), 1'b1);
		end
		load_weights(WEIGHT_ROUND_RST, WEIGHT_SQUARE_RST, WEIGHT_CURLY_RST, WEIGHT_ANGLE_RST);
	endtask

	// fill the stack to the top, one more opener overflows, rest skipped
	task automatic test_overflow();
		src_gap_pct  = 5;
		sink_gap_pct = 10;
		repeat (DEPTH)
			send_char(bracket_char(kind_t'($urandom_range(3)), 1'b0), 1'b0);
		send_char(CH_OPEN_CURLY, 1'b0);
		send_char(CH_CLOSE_CURLY, 1'b0);
		send_char(CH_OPEN_ROUND, 1'b1);
		// fresh line works again after the clear
		send_char(CH_OPEN_ANGLE, 1'b0);
		send_char(CH_CLOSE_ANGLE, 1'b1);
		drain_results();
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		sink_hold    = 200;
		repeat (6)
			send_random_line();
		drain_results();
	endtask

	// random lines in phases, each with its own weights and idle mix
	task automatic test_random();
		int phase_end;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: load_weights('1, '1, '1, '1);
				1: load_weights('0, '0, '0, '0);
				default: load_weights(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			endcase
			case (phase)
				0: begin src_gap_pct = 0;  sink_gap_pct = 0;  end
				1: begin src_gap_pct = 30; sink_gap_pct = 30; end
				2: begin src_gap_pct = 10; sink_gap_pct = 50; end
				3: begin src_gap_pct = 50; sink_gap_pct = 10; end
				default: begin src_gap_pct = 20; sink_gap_pct = 20; end
			endcase
			phase_end = items_sent + 80;
			while (items_sent < phase_end)
				send_random_line();
		end
		drain_results();
	endtask

	initial begin
		errors       = 0;
		items_sent   = 0;
		cycle_count  = 0;
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		sink_hold    = 0;
		line_depth   = 0;
		line_failed  = 1'b0;
		score_total  = '0;
		kind_weight[KIND_ROUND]  = WEIGHT_ROUND_RST;
		kind_weight[KIND_SQUARE] = WEIGHT_SQUARE_RST;
		kind_weight[KIND_CURLY]  = WEIGHT_CURLY_RST;
		kind_weight[KIND_ANGLE]  = WEIGHT_ANGLE_RST;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_WEIGHT_ROUND;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_weights();
		test_overflow();
		test_backpressure();
		test_random();

		// catch any stray result after the last expected one
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
